[hdl/llc_pkg.sv]
// ============================================================================
// llc_pkg
// Shared types and constants for the light list compaction block.
// ============================================================================
package llc_pkg;

    localparam int unsigned MaxCells        = 65536;
    localparam int unsigned MaxLights       = 4096;
    localparam int unsigned MaxListEntries  = 268435456;

    localparam int unsigned CellCountW      = 17;
    localparam int unsigned LightCountW     = 13;
    localparam int unsigned CapW            = 29;
    localparam int unsigned CellIdxW        = 16;
    localparam int unsigned LightIdxW       = 12;
    localparam int unsigned AddrW           = 28;
    localparam int unsigned CellCntW        = 13;
    localparam int unsigned TotalW          = 29;
    localparam int unsigned CfgIdxW         = 2;
    localparam int unsigned CfgDataW        = 29;
    localparam int unsigned InDataW         = 8;
    localparam int unsigned OutDataW        = 216;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_CELL_COUNT    = 2'd0,
        CFG_LIGHT_COUNT   = 2'd1,
        CFG_LIST_CAPACITY = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        KIND_ENTRY = 1'b0,
        KIND_CELL  = 1'b1
    } record_kind_t;

    typedef struct packed {
        record_kind_t           kind;
        logic [CellIdxW-1:0]    cell_index;
        logic [LightIdxW-1:0]   light_index;
        logic [AddrW-1:0]       list_address;
        logic [CapW-1:0]        cell_offset;
        logic [CellCntW-1:0]    cell_emitted;
        logic [CellCntW-1:0]    cell_attempted;
        logic [CellCntW-1:0]    cell_overflowed;
        logic [TotalW-1:0]      total_attempted;
        logic [TotalW-1:0]      total_emitted;
        logic [TotalW-1:0]      total_overflowed;
        logic                   last;
    } llc_result_t;

    typedef struct packed {
        logic [1:0]  count;
        llc_result_t first;
        llc_result_t second;
    } llc_push_t;

endpackage

[hdl/llc_core.sv]
// ============================================================================
// llc_core
// Configuration registers, batch counters and per-word result generation.
// ============================================================================
module llc_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [llc_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [llc_pkg::CfgDataW-1:0]   cfg_data,
    input  logic                           in_accept,
    input  logic                           overlap,
    output llc_pkg::llc_push_t             push
);
    import llc_pkg::*;

    logic [CellCountW-1:0]  cell_count_reg;
    logic [LightCountW-1:0] light_count_reg;
    logic [CapW-1:0]        list_capacity_reg;

    logic [LightIdxW-1:0]   light_pos_reg,  light_pos_next;
    logic [CellIdxW-1:0]    cell_pos_reg,   cell_pos_next;
    logic [TotalW-1:0]      list_fill_reg,  list_fill_next;
    logic [CapW-1:0]        cell_start_reg, cell_start_next;
    logic [CellCntW-1:0]    cell_em_reg,    cell_em_next;
    logic [CellCntW-1:0]    cell_ov_reg,    cell_ov_next;
    logic [TotalW-1:0]      att_total_reg,  att_total_next;
    logic [TotalW-1:0]      ov_total_reg,   ov_total_next;

    logic [CellCountW-1:0]  cells_eff;
    logic [LightCountW-1:0] lights_eff;
    logic [CapW-1:0]        cap_eff;
    logic                   end_cell;
    logic                   end_batch;
    logic                   emit;
    logic                   drop;
    logic [TotalW-1:0]      att_new;
    logic [TotalW-1:0]      fill_new;
    logic [TotalW-1:0]      ovt_new;
    logic [CellCntW-1:0]    cem_new;
    logic [CellCntW-1:0]    cov_new;
    logic [CellCntW:0]      att_sum;
    llc_result_t            entry;
    llc_result_t            record;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_count_reg    <= CellCountW'(1);
            light_count_reg   <= LightCountW'(1);
            list_capacity_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                CFG_CELL_COUNT:    cell_count_reg    <= cfg_data[CellCountW-1:0];
                CFG_LIGHT_COUNT:   light_count_reg   <= cfg_data[LightCountW-1:0];
                CFG_LIST_CAPACITY: list_capacity_reg <= cfg_data[CapW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (cell_count_reg == '0) begin
            cells_eff = CellCountW'(1);
        end else if (cell_count_reg > CellCountW'(MaxCells)) begin
            cells_eff = CellCountW'(MaxCells);
        end else begin
            cells_eff = cell_count_reg;
        end
        if (light_count_reg == '0) begin
            lights_eff = LightCountW'(1);
        end else if (light_count_reg > LightCountW'(MaxLights)) begin
            lights_eff = LightCountW'(MaxLights);
        end else begin
            lights_eff = light_count_reg;
        end
        if (list_capacity_reg > CapW'(MaxListEntries)) begin
            cap_eff = CapW'(MaxListEntries);
        end else begin
            cap_eff = list_capacity_reg;
        end

        end_cell  = {1'b0, light_pos_reg} >= (lights_eff - LightCountW'(1));
        end_batch = end_cell && ({1'b0, cell_pos_reg} >= (cells_eff - CellCountW'(1)));
        emit      = overlap && (list_fill_reg < cap_eff);
        drop      = overlap && !(list_fill_reg < cap_eff);

        att_new  = (overlap && att_total_reg != '1) ? att_total_reg + TotalW'(1)
                                                     : att_total_reg;
        fill_new = (emit && list_fill_reg != '1) ? list_fill_reg + TotalW'(1)
                                                  : list_fill_reg;
        ovt_new  = (drop && ov_total_reg != '1) ? ov_total_reg + TotalW'(1)
                                                 : ov_total_reg;
        cem_new  = (emit && cell_em_reg != '1) ? cell_em_reg + CellCntW'(1) : cell_em_reg;
        cov_new  = (drop && cell_ov_reg != '1) ? cell_ov_reg + CellCntW'(1) : cell_ov_reg;
        att_sum  = {1'b0, cem_new} + {1'b0, cov_new};

        entry                  = '0;
        entry.kind             = KIND_ENTRY;
        entry.cell_index       = cell_pos_reg;
        entry.light_index      = light_pos_reg;
        entry.list_address     = list_fill_reg[AddrW-1:0];
        entry.total_attempted  = att_new;
        entry.total_emitted    = fill_new;
        entry.total_overflowed = ovt_new;
        entry.last             = !end_cell;

        record                  = '0;
        record.kind             = KIND_CELL;
        record.cell_index       = cell_pos_reg;
        record.cell_offset      = cell_start_reg;
        record.cell_emitted     = cem_new;
        record.cell_attempted   = att_sum[CellCntW] ? '1 : att_sum[CellCntW-1:0];
        record.cell_overflowed  = cov_new;
        record.total_attempted  = att_new;
        record.total_emitted    = fill_new;
        record.total_overflowed = ovt_new;
        record.last             = 1'b1;

        push.first  = emit ? entry : record;
        push.second = record;
        if (!in_accept) begin
            push.count = 2'd0;
        end else begin
            push.count = 2'({1'b0, emit} + {1'b0, end_cell});
        end

        light_pos_next  = light_pos_reg + LightIdxW'(1);
        cell_pos_next   = cell_pos_reg;
        list_fill_next  = fill_new;
        cell_start_next = cell_start_reg;
        cell_em_next    = cem_new;
        cell_ov_next    = cov_new;
        att_total_next  = att_new;
        ov_total_next   = ovt_new;
        if (end_batch) begin
            light_pos_next  = '0;
            cell_pos_next   = '0;
            list_fill_next  = '0;
            cell_start_next = '0;
            cell_em_next    = '0;
            cell_ov_next    = '0;
            att_total_next  = '0;
            ov_total_next   = '0;
        end else if (end_cell) begin
            light_pos_next  = '0;
            cell_pos_next   = cell_pos_reg + CellIdxW'(1);
            cell_start_next = fill_new;
            cell_em_next    = '0;
            cell_ov_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_pos_reg  <= '0;
            cell_pos_reg   <= '0;
            list_fill_reg  <= '0;
            cell_start_reg <= '0;
            cell_em_reg    <= '0;
            cell_ov_reg    <= '0;
            att_total_reg  <= '0;
            ov_total_reg   <= '0;
        end else if (in_accept) begin
            light_pos_reg  <= light_pos_next;
            cell_pos_reg   <= cell_pos_next;
            list_fill_reg  <= list_fill_next;
            cell_start_reg <= cell_start_next;
            cell_em_reg    <= cell_em_next;
            cell_ov_reg    <= cell_ov_next;
            att_total_reg  <= att_total_next;
            ov_total_reg   <= ov_total_next;
        end
    end

endmodule

[hdl/llc_out_fifo.sv]
// ============================================================================
// llc_out_fifo
// Four-word result queue that takes up to two words per cycle.
// ============================================================================
module llc_out_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  llc_pkg::llc_push_t    push,
    input  logic                  pop,
    output logic                  out_valid,
    output llc_pkg::llc_result_t  out_word,
    output logic                  room_for_two
);
    import llc_pkg::*;

    localparam int unsigned Depth = 4;
    localparam int unsigned PtrW  = $clog2(Depth);
    localparam int unsigned CntW  = $clog2(Depth + 1);

    llc_result_t         mem [Depth];
    logic [PtrW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]     count_reg,  count_next;
    logic                do_pop;

    assign out_valid    = count_reg != '0;
    assign out_word     = mem[rd_ptr_reg];
    assign room_for_two = count_reg <= CntW'(Depth - 2);
    assign do_pop       = pop && out_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PtrW'(push.count);
        rd_ptr_next = rd_ptr_reg + PtrW'(do_pop);
        count_next  = count_reg + CntW'(push.count) - CntW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_reg + PtrW'(1)] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hdl/light_list_compaction.sv]
// ============================================================================
// light_list_compaction
// Compacts a cell-major stream of overlap bits into light-index entries
// and per-cell range records.
//
// The slave stream carries one overlap bit per word, cell-major, light
// index running fastest. Each accepted word yields no result, a light-index
// entry, a cell record, or an entry followed by a cell record, on the
// master stream. The counters walk lights and cells internally and return
// to zero after the last light of the last cell.
// A result enters the result queue at the edge that accepts its input
// word. The slave side takes one word per cycle while s_tready is high;
// a word that yields two results writes both into the four-word result
// queue, which hands them out one by one. s_tready falls when fewer than
// two queue slots are free, so a stalled receiver holds results in the
// queue without loss. Reset clears all counters and the queue and sets
// cell_count and light_count to one and list_capacity to zero. The user
// must write the configuration port only while idle; nothing enforces it.
// ============================================================================
module light_list_compaction (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [llc_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [llc_pkg::CfgDataW-1:0]    cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [llc_pkg::InDataW-1:0]     s_tdata,   // overlap
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // cell_index, light_index, list_address, cell_offset, cell_emitted,
    // cell_attempted, cell_overflowed, total_attempted, total_emitted,
    // total_overflowed
    output logic [llc_pkg::OutDataW-1:0]    m_tdata,
    output logic                            m_tuser,   // record_kind
    output logic                            m_tlast
);
    import llc_pkg::*;

    localparam int unsigned PadW = OutDataW - (CellIdxW + LightIdxW + AddrW + CapW
                                   + 3 * CellCntW + 3 * TotalW);

    llc_push_t   push;
    llc_result_t head;
    logic        in_accept;

    assign in_accept = s_tvalid && s_tready;

    llc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .overlap   (s_tdata[0]),
        .push      (push)
    );

    llc_out_fifo u_out_fifo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (push),
        .pop          (m_tready),
        .out_valid    (m_tvalid),
        .out_word     (head),
        .room_for_two (s_tready)
    );

    assign m_tdata = {PadW'(0), head.total_overflowed, head.total_emitted,
                      head.total_attempted, head.cell_overflowed, head.cell_attempted,
                      head.cell_emitted, head.cell_offset, head.list_address,
                      head.light_index, head.cell_index};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

[test/testbench.sv]
// ============================================================================
// Light list compaction testbench
// Drives overlap words into the compaction block and checks every result
// word against a cycle-free predictor of entries and cell records. A short
// directed part covers the count and capacity edge cases and mid-batch
// shrinking; random phases then vary the registers, the overlap density,
// the sender's bursts and the receiver's stall patterns, including one
// long receiver hold-off that backs the block up.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import llc_pkg::*;

    localparam int unsigned CycleLimit = 300000;
    localparam int unsigned RandomWords = 500;
    localparam logic [CfgIdxW-1:0] CfgUnknown = 2'd3;

    typedef struct packed {
        logic [TotalW-1:0]    total_overflowed;
        logic [TotalW-1:0]    total_emitted;
        logic [TotalW-1:0]    total_attempted;
        logic [CellCntW-1:0]  cell_overflowed;
        logic [CellCntW-1:0]  cell_attempted;
        logic [CellCntW-1:0]  cell_emitted;
        logic [CapW-1:0]      cell_offset;
        logic [AddrW-1:0]     list_address;
        logic [LightIdxW-1:0] light_index;
        logic [CellIdxW-1:0]  cell_index;
    } result_word_t;

    class compaction_tracker;
        logic [CellCountW-1:0]  cells_reg = 1;
        logic [LightCountW-1:0] lights_reg = 1;
        logic [CapW-1:0]        capacity_reg = 0;

        logic [LightIdxW-1:0]   light_pos = 0;
        logic [CellIdxW-1:0]    cell_pos = 0;
        logic [CapW-1:0]        fill = 0;
        logic [CapW-1:0]        cell_base = 0;
        logic [CellCntW-1:0]    cell_emits = 0;
        logic [CellCntW-1:0]    cell_drops = 0;
        logic [TotalW-1:0]      overlap_total = 0;
        logic [TotalW-1:0]      drop_total = 0;

        llc_result_t            pending_records[$];
        int unsigned            mismatches = 0;

        function void configure(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
            case (idx)
                CFG_CELL_COUNT:    cells_reg = data[CellCountW-1:0];
                CFG_LIGHT_COUNT:   lights_reg = data[LightCountW-1:0];
                CFG_LIST_CAPACITY: capacity_reg = data[CapW-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned outstanding();
            return pending_records.size();
        endfunction

        function void add_pending(llc_result_t r);
            pending_records.insert(pending_records.size(), r);
        endfunction

        function void take_overlap(logic overlap);
            int unsigned      cells;
            int unsigned      lights;
            logic [CapW-1:0]  cap;
            logic [CellCntW:0] cell_sum;
            bit               end_cell;
            bit               end_batch;
            llc_result_t      rec;

            cells = (cells_reg == 0) ? 1 : (cells_reg > MaxCells) ? MaxCells : cells_reg;
            lights = (lights_reg == 0) ? 1 : (lights_reg > MaxLights) ? MaxLights : lights_reg;
            cap = (capacity_reg > MaxListEntries) ? CapW'(MaxListEntries) : capacity_reg;
            end_cell = (light_pos >= lights - 1);
            end_batch = end_cell && (cell_pos >= cells - 1);

            if (overlap) begin
                if (overlap_total != '1) overlap_total++;
                if (fill < cap) begin
                    rec = '0;
                    rec.kind = KIND_ENTRY;
                    rec.cell_index = cell_pos;
                    rec.light_index = light_pos;
                    rec.list_address = fill[AddrW-1:0];
                    if (fill != '1) fill++;
                    if (cell_emits != '1) cell_emits++;
                    rec.total_attempted = overlap_total;
                    rec.total_emitted = fill;
                    rec.total_overflowed = drop_total;
                    rec.last = !end_cell;
                    add_pending(rec);
                end else begin
                    if (cell_drops != '1) cell_drops++;
                    if (drop_total != '1) drop_total++;
                end
            end

            if (end_cell) begin
                cell_sum = cell_emits + cell_drops;
                rec = '0;
                rec.kind = KIND_CELL;
                rec.cell_index = cell_pos;
                rec.cell_offset = cell_base;
                rec.cell_emitted = cell_emits;
                rec.cell_attempted = cell_sum[CellCntW] ? '1 : cell_sum[CellCntW-1:0];
                rec.cell_overflowed = cell_drops;
                rec.total_attempted = overlap_total;
                rec.total_emitted = fill;
                rec.total_overflowed = drop_total;
                rec.last = 1'b1;
                add_pending(rec);
                if (end_batch) begin
                    cell_pos = 0;
                    fill = 0;
                    cell_base = 0;
                    overlap_total = 0;
                    drop_total = 0;
                end else begin
                    if (cell_pos != '1) cell_pos++;
                    cell_base = fill;
                end
                light_pos = 0;
                cell_emits = 0;
                cell_drops = 0;
            end else begin
                light_pos++;
            end
        endfunction

        function string show(llc_result_t r);
            return $sformatf({"kind=%0d cell=%0d light=%0d addr=%0d off=%0d em=%0d at=%0d",
                              " ov=%0d tot_at=%0d tot_em=%0d tot_ov=%0d last=%0d"},
                             r.kind, r.cell_index, r.light_index, r.list_address,
                             r.cell_offset, r.cell_emitted, r.cell_attempted,
                             r.cell_overflowed, r.total_attempted, r.total_emitted,
                             r.total_overflowed, r.last);
        endfunction

        function void check_result(llc_result_t got);
            llc_result_t want;
            string       bad;

            bad = "";
            if (pending_records.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing expected: %s", $time, show(got));
                return;
            end
            want = pending_records.pop_front();
            if (got.kind !== want.kind) bad = {bad, " kind"};
            if (got.cell_index !== want.cell_index) bad = {bad, " cell_index"};
            if (got.light_index !== want.light_index) bad = {bad, " light_index"};
            if (got.list_address !== want.list_address) bad = {bad, " list_address"};
            if (got.cell_offset !== want.cell_offset) bad = {bad, " cell_offset"};
            if (got.cell_emitted !== want.cell_emitted) bad = {bad, " cell_emitted"};
            if (got.cell_attempted !== want.cell_attempted) bad = {bad, " cell_attempted"};
            if (got.cell_overflowed !== want.cell_overflowed) bad = {bad, " cell_overflowed"};
            if (got.total_attempted !== want.total_attempted) bad = {bad, " total_attempted"};
            if (got.total_emitted !== want.total_emitted) bad = {bad, " total_emitted"};
            if (got.total_overflowed !== want.total_overflowed) bad = {bad, " total_overflowed"};
            if (got.last !== want.last) bad = {bad, " last"};
            if (bad != "") begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch in%s", $time, bad);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CfgIdxW-1:0]     cfg_index = '0;
    logic [CfgDataW-1:0]    cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [InDataW-1:0]     s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OutDataW-1:0]    m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    compaction_tracker      tracker;
    int unsigned            accepted_words = 0;
    int unsigned            offered_words = 0;
    int unsigned            burst_left = 0;
    int unsigned            cycles = 0;

    light_list_compaction DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles == CycleLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        result_word_t w;
        llc_result_t  got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                tracker.take_overlap(s_tdata[0]);
                accepted_words++;
            end
            if (m_tvalid && m_tready) begin
                w = result_word_t'(m_tdata[$bits(result_word_t)-1:0]);
                got.kind = record_kind_t'(m_tuser);
                got.cell_index = w.cell_index;
                got.light_index = w.light_index;
                got.list_address = w.list_address;
                got.cell_offset = w.cell_offset;
                got.cell_emitted = w.cell_emitted;
                got.cell_attempted = w.cell_attempted;
                got.cell_overflowed = w.cell_overflowed;
                got.total_attempted = w.total_attempted;
                got.total_emitted = w.total_emitted;
                got.total_overflowed = w.total_overflowed;
                got.last = m_tlast;
                tracker.check_result(got);
            end
        end
    end

    // Receiver: changes its stall pattern every so often and holds off once for a long time.
    initial begin
        int unsigned mode;
        int unsigned span;
        int unsigned tick;
        bit          held;
        logic        ready;

        held = 0;
        tick = 0;
        @(posedge aclk iff aresetn);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span) begin
                if (!held && accepted_words >= 120) begin
                    held = 1;
                    m_tready <= 1'b0;
                    repeat (400) @(posedge aclk);
                end
                tick++;
                case (mode)
                    0: ready = 1'b1;
                    1: ready = 1'($urandom_range(0, 1));
                    2: ready = ($urandom_range(0, 7) == 0);
                    default: ready = (tick % 3 != 0);
                endcase
                m_tready <= ready;
                @(posedge aclk);
            end
        end
    end

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.configure(idx, data);
        @(posedge aclk);
    endtask

    task automatic offer(input logic overlap);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        offered_words++;
        s_tvalid <= 1'b1;
        s_tdata <= {{(InDataW-1){1'b0}}, overlap};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_pattern(input logic [31:0] bits, input int unsigned count);
        for (int unsigned i = 0; i < count; i++) offer(bits[i]);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [CfgDataW-1:0] pick_value(int unsigned mid, int unsigned width,
                                                        longint unsigned limit);
        longint unsigned full;
        longint unsigned v;
        full = (64'd1 << width) - 1;
        case ($urandom_range(0, 19))
            0, 1:    v = 0;
            2, 3:    v = full;
            4:       v = limit;
            5, 6:    v = {$urandom(), $urandom()} & full;
            7, 8, 9: v = $urandom_range(1, mid * 5);
            default: v = $urandom_range(1, mid);
        endcase
        if (width < CfgDataW && $urandom_range(0, 3) == 0)
            v = v | ((longint'($urandom()) << width) & ((64'd1 << CfgDataW) - 1));
        return CfgDataW'(v);
    endfunction

    initial begin
        int unsigned words;
        int unsigned density;

        tracker = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_pattern(32'b01, 2);
        settle();

        write_reg(CFG_CELL_COUNT, 29'd0);
        write_reg(CFG_LIGHT_COUNT, 29'd0);
        write_reg(CFG_LIST_CAPACITY, 29'd2);
        write_reg(CfgUnknown, 29'h1FFFFFFF);
        send_pattern(32'b011, 3);
        settle();

        write_reg(CFG_CELL_COUNT, 29'd3);
        write_reg(CFG_LIGHT_COUNT, 29'd4);
        write_reg(CFG_LIST_CAPACITY, 29'd5);
        send_pattern(32'hB7B, 12);
        settle();

        write_reg(CFG_CELL_COUNT, 29'h1FFFF);
        write_reg(CFG_LIGHT_COUNT, 29'h1FFF);
        write_reg(CFG_LIST_CAPACITY, 29'h1FFFFFFF);
        send_pattern(32'b1101, 4);
        settle();

        write_reg(CFG_LIGHT_COUNT, 29'd2);
        write_reg(CFG_LIST_CAPACITY, 29'd1);
        send_pattern(32'b011, 3);
        settle();

        write_reg(CFG_CELL_COUNT, 29'd1);
        send_pattern(32'b11, 2);
        settle();

        offered_words = 0;
        while (offered_words < RandomWords) begin
            if ($urandom_range(0, 9) < 7)
                write_reg(CFG_CELL_COUNT, pick_value(4, CellCountW, MaxCells));
            if ($urandom_range(0, 9) < 7)
                write_reg(CFG_LIGHT_COUNT, pick_value(6, LightCountW, MaxLights));
            if ($urandom_range(0, 9) < 7)
                write_reg(CFG_LIST_CAPACITY, pick_value(12, CapW, MaxListEntries));
            if ($urandom_range(0, 15) == 0)
                write_reg(CfgUnknown, CfgDataW'($urandom()));
            words = $urandom_range(8, 50);
            density = $urandom_range(0, 100);
            repeat (words) offer($urandom_range(0, 99) < density);
            settle();
        end

        repeat (20) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
